@@ rtl/hrf_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request framer package
// Shared constants, types and the key text for the request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

   localparam int LENGTH_BITS_DEF = 32;
   localparam int BODY_LEN_W      = 32;
   localparam int KEY_LEN         = 16;
   localparam int KEY_IDX_W       = $clog2(KEY_LEN);
   localparam int KEY_CNT_W       = $clog2(KEY_LEN + 1);

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic {
      PH_HEADER,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      VP_KEY,
      VP_SKIP,
      VP_DIGITS,
      VP_DONE
   } value_phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NO_DIGITS,
      ST_SATURATED
   } status_type;

   // Handshake from the framer to the length parser for one transfer.
   typedef struct packed {
      logic advance;
      logic finish;
   } hrf_ctl_type;

   // The key "Content-Length: ", one character per index.
   function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6f; // o
         4'd2:    c = 8'h6e; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6e; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2d; // -
         4'd8:    c = 8'h4c; // L
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6e; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3a; // :
         4'd15:   c = 8'h20; // space
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/hrf_channels_if.sv @@
// ----------------------------------------------------------------------------
// Request framer channels
// Valid/ready channels for the incoming byte stream and the tagged results.
// ----------------------------------------------------------------------------
interface hrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        in_body;
   logic        header_end;
   logic        message_end;
   logic [31:0] body_length;
   logic [1:0]  length_status;

   modport source (output valid, output out_byte, output in_body, output header_end,
                   output message_end, output body_length, output length_status,
                   input ready);
   modport sink   (input valid, input out_byte, input in_body, input header_end,
                   input message_end, input body_length, input length_status,
                   output ready);
endinterface

@@ rtl/http_request_framer_top.sv @@
// ----------------------------------------------------------------------------
// HTTP request framer
// Tags a request byte stream as header or body, using CR LF CR LF and the
// Content-Length value to find where each request ends.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  req_bus   in         data_byte
//  rsp_bus   out        out_byte, in_body, header_end, message_end,
//                       body_length, length_status
//
//  One result per accepted byte, registered and shown in the cycle after it is accepted.
//  A byte can be accepted in every cycle while results are taken; the rate is
//  set by the single result register, which refills in the cycle it is read.
//  Reset is synchronous and returns the framer to the header phase.
//  When the result is not taken, req_bus.ready drops until it is.
// ----------------------------------------------------------------------------
module http_request_framer_top #(
   parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hrf_req_if.sink   req_bus,
   hrf_rsp_if.source rsp_bus
);
   import hrf_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [1:0]             term_ff, term_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             out_byte_ff;
   logic                   in_body_ff, header_end_ff, message_end_ff;
   logic [BODY_LEN_W-1:0]  body_length_ff;
   status_type             status_out_ff;

   logic                   accept;
   logic                   in_header;
   logic                   done;
   logic                   msg_end;
   hrf_ctl_type            ctl;
   logic [LENGTH_BITS-1:0] length_value;
   status_type             length_status;
   logic [BODY_LEN_W-1:0]  length_low;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_header     = (phase_ff == PH_HEADER);
   assign done          = in_header && (term_ff == 2'd3) && (req_bus.data_byte == CHAR_LF);

   assign ctl.advance = accept && in_header && !done;
   assign ctl.finish  = accept && done;

   hrf_length_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_length_parser (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .data_byte     (req_bus.data_byte),
      .length_value  (length_value),
      .length_status (length_status)
   );

   if (LENGTH_BITS >= BODY_LEN_W) begin : g_len_trunc
      assign length_low = length_value[BODY_LEN_W-1:0];
   end else begin : g_len_ext
      assign length_low = {{(BODY_LEN_W-LENGTH_BITS){1'b0}}, length_value};
   end

   always_comb begin
      phase_in     = phase_ff;
      term_in      = term_ff;
      remaining_in = remaining_ff;
      msg_end      = 1'b0;
      if (accept) begin
         if (!in_header) begin
            // The count is at least one throughout the body.
            remaining_in = remaining_ff - 1'b1;
            if (remaining_ff == LENGTH_BITS'(1)) begin
               msg_end  = 1'b1;
               phase_in = PH_HEADER;
            end
         end else if (done) begin
            term_in = 2'd0;
            if (length_value == '0) begin
               msg_end = 1'b1;
            end else begin
               remaining_in = length_value;
               phase_in     = PH_BODY;
            end
         end else if ((term_ff == 2'd0 || term_ff == 2'd2) &&
                      req_bus.data_byte == CHAR_CR) begin
            term_in = term_ff + 2'd1;
         end else if (term_ff == 2'd1 && req_bus.data_byte == CHAR_LF) begin
            term_in = 2'd2;
         end else begin
            term_in = (req_bus.data_byte == CHAR_CR) ? 2'd1 : 2'd0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         term_ff      <= 2'd0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         term_ff      <= term_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_byte_ff    <= req_bus.data_byte;
         in_body_ff     <= !in_header;
         header_end_ff  <= done;
         message_end_ff <= msg_end;
         body_length_ff <= done ? length_low : '0;
         status_out_ff  <= done ? length_status : ST_OK;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_byte      = out_byte_ff;
   assign rsp_bus.in_body       = in_body_ff;
   assign rsp_bus.header_end    = header_end_ff;
   assign rsp_bus.message_end   = message_end_ff;
   assign rsp_bus.body_length   = body_length_ff;
   assign rsp_bus.length_status = status_out_ff;

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> remaining_ff != '0)
      else $error("body phase with no bytes remaining");

   a_body_no_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && in_body_ff |-> !header_end_ff && status_out_ff == ST_OK)
      else $error("body byte carries header end tags");

   a_empty_body: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && header_end_ff && message_end_ff |-> body_length_ff == '0)
      else $error("request ended at header end with a nonzero length");

   a_body_start: assert property (@(posedge clock) disable iff (reset)
      accept && done && length_value != '0 |=> phase_ff == PH_BODY)
      else $error("nonzero length did not enter the body phase");

endmodule

@@ rtl/hrf_length_parser.sv @@
// ----------------------------------------------------------------------------
// Content-Length parser
// Finds the first length key in a header and accumulates its decimal value.
// ----------------------------------------------------------------------------
module hrf_length_parser #(
   parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hrf_pkg::hrf_ctl_type     ctl,
   input  logic [7:0]               data_byte,
   output logic [LENGTH_BITS-1:0]   length_value,
   output hrf_pkg::status_type      length_status
);
   import hrf_pkg::*;

   logic [KEY_CNT_W-1:0]   key_match_ff, key_match_in;
   value_phase_type        value_phase_ff, value_phase_in;
   logic [LENGTH_BITS-1:0] accum_ff, accum_in;
   status_type             status_ff, status_in;

   logic                   is_digit;
   logic [LENGTH_BITS+3:0] scaled;
   logic                   overflow;

   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);

   // Times ten as two shifts, plus the digit; any carry into the top four bits
   // means the value no longer fits.
   assign scaled = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                   + {{LENGTH_BITS{1'b0}}, data_byte[3:0]};
   assign overflow = |scaled[LENGTH_BITS+3:LENGTH_BITS];

   always_comb begin
      key_match_in   = key_match_ff;
      value_phase_in = value_phase_ff;
      accum_in       = accum_ff;
      status_in      = status_ff;
      if (ctl.finish) begin
         key_match_in   = '0;
         value_phase_in = VP_KEY;
         accum_in       = '0;
         status_in      = ST_OK;
      end else if (ctl.advance) begin
         case (value_phase_ff)
            VP_KEY: begin
               if (data_byte == key_char(key_match_ff[KEY_IDX_W-1:0])) begin
                  key_match_in = key_match_ff + 1'b1;
               end else if (data_byte == key_char('0)) begin
                  key_match_in = KEY_CNT_W'(1);
               end else begin
                  key_match_in = '0;
               end
               if (key_match_in == KEY_CNT_W'(KEY_LEN)) begin
                  value_phase_in = VP_SKIP;
               end
            end
            VP_SKIP, VP_DIGITS: begin
               if (is_digit) begin
                  value_phase_in = VP_DIGITS;
                  if (overflow) begin
                     accum_in  = '1;
                     status_in = ST_SATURATED;
                  end else begin
                     accum_in = scaled[LENGTH_BITS-1:0];
                  end
               end else if (value_phase_ff == VP_SKIP && data_byte == CHAR_SPACE) begin
                  value_phase_in = VP_SKIP;
               end else begin
                  if (value_phase_ff == VP_SKIP) begin
                     status_in = ST_NO_DIGITS;
                  end
                  value_phase_in = VP_DONE;
               end
            end
            default: begin
               value_phase_in = value_phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_match_ff   <= '0;
         value_phase_ff <= VP_KEY;
         accum_ff       <= '0;
         status_ff      <= ST_OK;
      end else begin
         key_match_ff   <= key_match_in;
         value_phase_ff <= value_phase_in;
         accum_ff       <= accum_in;
         status_ff      <= status_in;
      end
   end

   // A header that ends while spaces are still skipped had no digits.
   assign length_value  = accum_ff;
   assign length_status = (value_phase_ff == VP_SKIP) ? ST_NO_DIGITS : status_ff;

   a_key_complete: assert property (@(posedge clock) disable iff (reset)
      value_phase_ff != VP_KEY |-> key_match_ff == KEY_CNT_W'(KEY_LEN))
      else $error("value tracking started without a full key match");

   a_key_bound: assert property (@(posedge clock) disable iff (reset)
      value_phase_ff == VP_KEY |-> key_match_ff < KEY_CNT_W'(KEY_LEN))
      else $error("key match count out of range");

   a_saturated_max: assert property (@(posedge clock) disable iff (reset)
      status_ff == ST_SATURATED |-> accum_ff == {LENGTH_BITS{1'b1}})
      else $error("saturated length is not the maximum value");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      value_phase_ff == VP_SKIP |-> accum_ff == '0)
      else $error("length accumulated before the first digit");

endmodule
